### rtl/sm4_pkg.sv
// package: sm4 types, constants, sbox and round functions
package sm4_pkg;
   localparam int ROUNDS_DEFAULT = 32;
   localparam logic [31:0] CK_INIT = 32'h140E0600;
   localparam logic [31:0] CK_XOR  = 32'h01000100;
   localparam logic [31:0] CK_ADD  = 32'h1C1C1C1C;
   localparam logic [31:0] CK_MASK = 32'hFEFEFEFE;
   localparam logic [31:0] FK0 = 32'hC6BAB1A3;
   localparam logic [31:0] FK1 = 32'h5033AA56;
   localparam logic [31:0] FK2 = 32'h97917D67;
   localparam logic [31:0] FK3 = 32'hDC2270B2;

   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_DECRYPT  = 2'd2;

   typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ROUND, ST_DONE} state_type;

   typedef struct packed {
      logic load_key;
      logic load_block;
      logic step_key;
      logic step_data;
      logic capture;
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] tau(input logic [31:0] x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic logic [31:0] t_data(input logic [31:0] x);
      logic [31:0] b;
      b = tau(x);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   function automatic logic [31:0] t_key(input logic [31:0] x);
      logic [31:0] b;
      b = tau(x);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction
endpackage

### rtl/sm4_stream_if.sv
// interface: valid/ready channel carrying two 64-bit halves
interface sm4_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] low;
   logic [63:0] high;
   modport source (output valid, output low, output high, input ready);
   modport sink (input valid, input low, input high, output ready);
endinterface

### rtl/sm4_ram.sv
// generic ram with separate write and read addresses and registered read
module sm4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

### rtl/sm4_datapath.sv
// datapath: key schedule and round state registers, result register
module sm4_datapath (
   input  logic                clock,
   input  sm4_pkg::cmd_type    cmd,
   input  logic [127:0]        key,
   input  logic [127:0]        block,
   input  logic [31:0]         rk,
   output logic [31:0]         new_rk,
   output logic [127:0]        result
);
   import sm4_pkg::*;

   logic [31:0]  k_ff [4];
   logic [31:0]  k_in [4];
   logic [31:0]  x_ff [4];
   logic [31:0]  x_in [4];
   logic [31:0]  ck_ff, ck_in;
   logic [127:0] res_ff, res_in;

   assign new_rk = k_ff[0] ^ t_key(k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ bswap(ck_ff ^ CK_XOR));

   always_comb begin
      k_in = k_ff;
      ck_in = ck_ff;
      x_in = x_ff;
      res_in = res_ff;
      if (cmd.load_key) begin
         k_in[0] = bswap(key[31:0])   ^ bswap(FK0);
         k_in[1] = bswap(key[63:32])  ^ bswap(FK1);
         k_in[2] = bswap(key[95:64])  ^ bswap(FK2);
         k_in[3] = bswap(key[127:96]) ^ bswap(FK3);
         ck_in = CK_INIT;
      end else if (cmd.step_key) begin
         k_in[0] = k_ff[1];
         k_in[1] = k_ff[2];
         k_in[2] = k_ff[3];
         k_in[3] = new_rk;
         ck_in = (ck_ff + CK_ADD) & CK_MASK;
      end
      if (cmd.load_block) begin
         x_in[0] = bswap(block[31:0]);
         x_in[1] = bswap(block[63:32]);
         x_in[2] = bswap(block[95:64]);
         x_in[3] = bswap(block[127:96]);
      end else if (cmd.step_data) begin
         x_in[0] = x_ff[1];
         x_in[1] = x_ff[2];
         x_in[2] = x_ff[3];
         x_in[3] = x_ff[0] ^ t_data(x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ rk);
      end
      if (cmd.capture)
         res_in = {bswap(x_in[0]), bswap(x_in[1]), bswap(x_in[2]), bswap(x_in[3])};
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      ck_ff <= ck_in;
      x_ff <= x_in;
      res_ff <= res_in;
   end
   assign result = res_ff;
endmodule

### rtl/sm4_controller.sv
// controller: sequences key expansion, rounds and result handshake
module sm4_controller #(
   parameter int ROUNDS = sm4_pkg::ROUNDS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             stale,
   input  logic             decrypt,
   output logic             clear_stale,
   output logic             rk_we,
   output logic [4:0]       rk_addr,
   output sm4_pkg::cmd_type cmd
);
   import sm4_pkg::*;
   localparam int NR = ROUNDS < 4 ? 4 : (ROUNDS > 32 ? 32 : ROUNDS);
   localparam logic [5:0] LAST = 6'(NR - 1);
   localparam logic [5:0] EXP_END = 6'(NR);

   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       accept;
   logic [5:0] ridx;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   // read address is formed from the next count so the registered ram has each round key ready when its round runs
   always_comb begin
      ridx = decrypt ? LAST - cnt_in : cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = stale ? ST_EXPAND : ST_ROUND;
            cnt_in = '0;
         end
         ST_EXPAND: if (cnt_ff == EXP_END) begin
            state_in = ST_ROUND;
            cnt_in = '0;
         end else cnt_in = cnt_ff + 6'd1;
         ST_ROUND: if (cnt_ff == LAST) state_in = ST_DONE;
            else cnt_in = cnt_ff + 6'd1;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (reset) begin
         state_in = ST_IDLE;
         cnt_in = '0;
      end
   end

   always_comb begin
      cmd = '0;
      req_ready = state_ff == ST_IDLE;
      rsp_valid = state_ff == ST_DONE;
      clear_stale = 1'b0;
      rk_we = 1'b0;
      rk_addr = ridx[4:0];
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_key = accept;
            cmd.load_block = accept;
         end
         ST_EXPAND: begin
            // the final expand step writes nothing and fetches the first round key
            if (cnt_ff != EXP_END) begin
               cmd.step_key = 1'b1;
               rk_we = 1'b1;
               rk_addr = cnt_ff[4:0];
            end
            clear_stale = cnt_ff == EXP_END;
         end
         ST_ROUND: begin
            cmd.step_data = 1'b1;
            cmd.capture = cnt_ff == LAST;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      cnt_ff <= cnt_in;
   end
endmodule

### rtl/sm4_block_cipher_engine.sv
// top level: sm4 block cipher engine with apb-style key/mode registers
// usage:
//   req channel carries one 128-bit block per beat (low/high halves),
//   rsp channel returns the encrypted or decrypted block.
//   csr port: key_low at 0x00, key_high at 0x08, decrypt_mode at 0x10.
// rounds: one block runs ROUNDS rounds (clamped to 4..32), one round
//   per cycle through a shared round unit; after reset or a key write,
//   the round keys are expanded first, at the next accepted block.
// blocks go one at a time: the next is accepted once the result is taken.
// reset: clears control, marks the keys for expansion; key and mode
//   registers read zero.
// stall: the result holds on rsp until taken; no new block is accepted
//   while a result waits.
module sm4_block_cipher_engine #(
   parameter int ROUNDS = sm4_pkg::ROUNDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   sm4_stream_if.sink  req,
   sm4_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import sm4_pkg::*;

   logic [63:0] key_low_ff, key_high_ff;
   logic        dec_ff, stale_ff;
   logic        wr, clear_stale, rk_we;
   logic [4:0]  rk_addr;
   logic [31:0] rk, new_rk;
   logic [1:0]  reg_idx;
   cmd_type     cmd;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
         dec_ff <= 1'b0;
         stale_ff <= 1'b1;
      end else begin
         if (clear_stale) stale_ff <= 1'b0;
         if (wr && csr_paddr[2:0] == 3'd0) begin
            unique case (reg_idx)
               REG_KEY_LOW: begin
                  key_low_ff <= csr_pwdata;
                  stale_ff <= 1'b1;
               end
               REG_KEY_HIGH: begin
                  key_high_ff <= csr_pwdata;
                  stale_ff <= 1'b1;
               end
               REG_DECRYPT: dec_ff <= csr_pwdata[0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_DECRYPT:  csr_prdata = {63'd0, dec_ff};
         default:      csr_prdata = '0;
      endcase
   end

   sm4_controller #(.ROUNDS(ROUNDS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stale(stale_ff), .decrypt(dec_ff), .clear_stale(clear_stale),
      .rk_we(rk_we), .rk_addr(rk_addr), .cmd(cmd)
   );

   sm4_ram #(.WIDTH(32), .DEPTH(32)) u_rk (
      .clock(clock), .we(rk_we), .waddr(rk_addr), .wdata(new_rk),
      .raddr(rk_addr), .rdata(rk)
   );

   sm4_datapath u_dp (
      .clock(clock), .cmd(cmd),
      .key({key_high_ff, key_low_ff}), .block({req.high, req.low}),
      .rk(rk), .new_rk(new_rk), .result({rsp.high, rsp.low})
   );

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while result pending");
   a_exp_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.step_data && !clear_stale) |-> !stale_ff || wr)
      else $error("rounds on stale keys");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.low))
      else $error("result dropped");
`endif
endmodule
